FILE: hdl/tlnf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnf_pkg
// Types and constants shared by the line numbering filter modules.
// ----------------------------------------------------------------------------
package tlnf_pkg;

  localparam logic [2:0] REG_SECTION_STYLES  = 3'd0;
  localparam logic [2:0] REG_LINE_INCREMENT  = 3'd1;
  localparam logic [2:0] REG_START_NUMBER    = 3'd2;
  localparam logic [2:0] REG_BLANK_GROUP     = 3'd3;
  localparam logic [2:0] REG_NUMBER_WIDTH    = 3'd4;
  localparam logic [2:0] REG_NUMBER_FORMAT   = 3'd5;
  localparam logic [2:0] REG_RESTART_DISABLE = 3'd6;
  localparam logic [2:0] REG_DELIMITER_PAIR  = 3'd7;

  localparam logic [1:0] STYLE_ALL      = 2'd0;
  localparam logic [1:0] STYLE_NONBLANK = 2'd1;

  localparam logic [1:0] FORMAT_LEFT  = 2'd0;
  localparam logic [1:0] FORMAT_ZEROS = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;

  localparam logic [2:0] MATCH_HEADER = 3'd6;
  localparam logic [2:0] MATCH_BODY   = 3'd4;
  localparam logic [2:0] MATCH_FOOTER = 3'd2;

  typedef enum logic [1:0] {
    SEC_BODY   = 2'd0,
    SEC_HEADER = 2'd1,
    SEC_FOOTER = 2'd2
  } section_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_MATCH  = 2'd1,
    PH_INSIDE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SEL_PREFIX  = 2'd0,
    SEL_HELD    = 2'd1,
    SEL_BYTE    = 2'd2,
    SEL_NEWLINE = 2'd3
  } emit_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CONV,
    ST_PREFIX,
    ST_HELD,
    ST_BYTE,
    ST_NEWLINE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic      load_in;
    logic      begin_line;
    logic      blank;
    logic      switch_sec;
    logic      conv_load;
    logic      conv_step;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      emit;
    emit_sel_t emit_sel;
    logic      last;
    logic      set_state;
    logic [2:0] match_new;
    phase_t    phase_new;
  } cmd_t;

  typedef struct packed {
    logic       eoi;
    phase_t     phase;
    logic [2:0] matched;
    logic       is_nl;
    logic       is_d0;
    logic       match_next;
    logic       numbered_next;
    logic       out_free;
    logic       pfx_end;
    logic       held_end;
    logic       conv_done;
  } status_t;

endpackage
`default_nettype wire

FILE: hdl/tlnf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnf_ctrl
// Sequencer that decides what each text beat causes and steps the datapath.
// ----------------------------------------------------------------------------
module tlnf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              text_valid,
  output logic                   text_stall,
  input  wire tlnf_pkg::status_t st,
  output tlnf_pkg::cmd_t         cmd
);

  tlnf_pkg::state_t state, state_next;
  logic p_held, p_byte, p_nl;
  logic [2:0] m_new;
  tlnf_pkg::phase_t ph_new;

  logic d_pre, d_blank, d_held, d_byte, d_nl, d_sw;
  logic [2:0] d_m;
  tlnf_pkg::phase_t d_ph;
  logic is_switch;
  tlnf_pkg::state_t after_pre, after_held, after_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlnf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tlnf_pkg::ST_DECIDE) begin
      p_held <= d_held;
      p_byte <= d_byte;
      p_nl   <= d_nl;
      m_new  <= d_m;
      ph_new <= d_ph;
    end
  end

  assign is_switch = (st.matched == tlnf_pkg::MATCH_HEADER) ||
                     (st.matched == tlnf_pkg::MATCH_BODY) ||
                     (st.matched == tlnf_pkg::MATCH_FOOTER);

  always_comb begin
    d_pre = 1'b0; d_blank = 1'b0; d_held = 1'b0; d_byte = 1'b0;
    d_nl = 1'b0; d_sw = 1'b0;
    d_m = 3'd0;
    d_ph = tlnf_pkg::PH_START;
    if (st.eoi) begin
      if (st.phase == tlnf_pkg::PH_MATCH) begin
        if (is_switch) begin
          d_sw = 1'b1; d_nl = 1'b1;
        end else begin
          d_pre = 1'b1; d_held = 1'b1;
        end
      end
    end else begin
      case (st.phase)
        tlnf_pkg::PH_START: begin
          if (st.is_nl) begin
            d_pre = 1'b1; d_blank = 1'b1; d_nl = 1'b1;
          end else if (st.is_d0) begin
            d_m = 3'd1; d_ph = tlnf_pkg::PH_MATCH;
          end else begin
            d_pre = 1'b1; d_byte = 1'b1; d_ph = tlnf_pkg::PH_INSIDE;
          end
        end
        tlnf_pkg::PH_MATCH: begin
          if (st.is_nl) begin
            if (is_switch) begin
              d_sw = 1'b1; d_nl = 1'b1;
            end else begin
              d_pre = 1'b1; d_held = 1'b1; d_nl = 1'b1;
            end
          end else if (st.match_next) begin
            d_m = st.matched + 3'd1; d_ph = tlnf_pkg::PH_MATCH;
          end else begin
            d_pre = 1'b1; d_held = 1'b1; d_byte = 1'b1; d_ph = tlnf_pkg::PH_INSIDE;
          end
        end
        default: begin
          d_byte = 1'b1;
          d_ph = st.is_nl ? tlnf_pkg::PH_START : tlnf_pkg::PH_INSIDE;
        end
      endcase
    end
  end

  always_comb begin
    after_byte = p_nl ? tlnf_pkg::ST_NEWLINE : tlnf_pkg::ST_FINISH;
    after_held = p_byte ? tlnf_pkg::ST_BYTE : after_byte;
    after_pre  = (p_held && st.matched != 3'd0) ? tlnf_pkg::ST_HELD : after_held;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.match_new = m_new;
    cmd.phase_new = ph_new;
    text_stall = (state != tlnf_pkg::ST_IDLE);
    case (state)
      tlnf_pkg::ST_IDLE: begin
        if (text_valid) begin
          cmd.load_in = 1'b1;
          state_next = tlnf_pkg::ST_DECIDE;
        end
      end
      tlnf_pkg::ST_DECIDE: begin
        cmd.cnt_clr = 1'b1;
        cmd.switch_sec = d_sw;
        cmd.blank = d_blank;
        if (d_pre) begin
          cmd.begin_line = 1'b1;
          cmd.conv_load = st.numbered_next;
          state_next = st.numbered_next ? tlnf_pkg::ST_CONV : tlnf_pkg::ST_PREFIX;
        end else if (d_byte) begin
          state_next = tlnf_pkg::ST_BYTE;
        end else if (d_nl) begin
          state_next = tlnf_pkg::ST_NEWLINE;
        end else begin
          state_next = tlnf_pkg::ST_FINISH;
        end
      end
      tlnf_pkg::ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (st.conv_done) begin
          state_next = tlnf_pkg::ST_PREFIX;
        end
      end
      tlnf_pkg::ST_PREFIX: begin
        cmd.emit_sel = tlnf_pkg::SEL_PREFIX;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (st.pfx_end) begin
            cmd.cnt_clr = 1'b1;
            cmd.last = (after_pre == tlnf_pkg::ST_FINISH);
            state_next = after_pre;
          end
        end
      end
      tlnf_pkg::ST_HELD: begin
        cmd.emit_sel = tlnf_pkg::SEL_HELD;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.cnt_inc = 1'b1;
          if (st.held_end) begin
            cmd.cnt_clr = 1'b1;
            cmd.last = (after_held == tlnf_pkg::ST_FINISH);
            state_next = after_held;
          end
        end
      end
      tlnf_pkg::ST_BYTE: begin
        cmd.emit_sel = tlnf_pkg::SEL_BYTE;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (after_byte == tlnf_pkg::ST_FINISH);
          state_next = after_byte;
        end
      end
      tlnf_pkg::ST_NEWLINE: begin
        cmd.emit_sel = tlnf_pkg::SEL_NEWLINE;
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          state_next = tlnf_pkg::ST_FINISH;
        end
      end
      tlnf_pkg::ST_FINISH: begin
        cmd.set_state = 1'b1;
        state_next = tlnf_pkg::ST_IDLE;
      end
      default: begin
        state_next = tlnf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/tlnf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlnf_dp
// Settings, line state, binary to decimal converter and output register.
// ----------------------------------------------------------------------------
module tlnf_dp #(
  parameter int MAX_WIDTH   = 16,
  parameter int NUMBER_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic [7:0]        input_byte,
  input  wire logic              end_of_input,
  output logic                   numbered_valid,
  input  wire logic              numbered_stall,
  output logic [7:0]             out_byte,
  output logic                   run_last,
  input  wire tlnf_pkg::cmd_t    cmd,
  output tlnf_pkg::status_t      st
);

  localparam int DIGITS = NUMBER_BITS * 30103 / 100000 + 1;
  localparam int DIW    = $clog2(DIGITS);
  localparam int CW     = $clog2(MAX_WIDTH + 8);
  localparam int AW     = (CW > DIW ? CW : DIW) + 1;
  localparam int XW     = NUMBER_BITS > 32 ? NUMBER_BITS : 32;
  localparam int KW     = $clog2(NUMBER_BITS);

  logic [5:0]  section_styles;
  logic [31:0] line_increment;
  logic [31:0] start_number;
  logic [15:0] blank_group;
  logic [4:0]  number_width;
  logic [1:0]  number_format;
  logic        restart_disable;
  logic [15:0] delimiter_pair;

  logic [NUMBER_BITS-1:0] line_number;
  logic [15:0]            blank_run;
  tlnf_pkg::section_t     current_section;
  logic [2:0]             delimiter_matched;
  tlnf_pkg::phase_t       line_phase;
  logic                   line_numbered;

  logic [7:0] in_byte;
  logic       in_eoi;
  logic [CW-1:0] cnt;
  logic [NUMBER_BITS-1:0] bin;
  logic [3:0] dig [DIGITS];
  logic [KW-1:0] ccnt;

  logic [XW-1:0] inc_x, start_x;
  logic [15:0]   blank_next;
  logic [1:0]    sec, style;
  logic          numbered_next;
  logic [CW-1:0] w;
  logic [AW-1:0] sig, len, kx, wx;
  logic [7:0]    pfx_char, delim_sel, emit_char;
  logic [DIW-1:0] didx;

  assign inc_x   = XW'(line_increment);
  assign start_x = XW'(start_number);

  always_comb begin
    if ({1'b0, number_width} > 6'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(number_width);
    end
  end

  always_comb begin
    if (cmd.blank) begin
      blank_next = (blank_run < blank_group) ? blank_run + 16'd1 : 16'd1;
    end else begin
      blank_next = 16'd0;
    end
    sec = (current_section == tlnf_pkg::SEC_HEADER) ? 2'd1 :
          (current_section == tlnf_pkg::SEC_FOOTER) ? 2'd2 : 2'd0;
    style = 2'(section_styles >> (3'd2 * 3'(sec)));
    if (style == tlnf_pkg::STYLE_ALL) begin
      numbered_next = !cmd.blank || (blank_next == blank_group);
    end else if (style == tlnf_pkg::STYLE_NONBLANK) begin
      numbered_next = !cmd.blank;
    end else begin
      numbered_next = 1'b0;
    end
  end

  always_comb begin
    sig = AW'(1);
    for (int i = 0; i < DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        sig = AW'(i + 1);
      end
    end
    wx = AW'(w);
    len = (sig > wx) ? wx : sig;
    kx = AW'(cnt);
    didx = '0;
    pfx_char = tlnf_pkg::CHAR_SPACE;
    if (kx == wx) begin
      pfx_char = line_numbered ? tlnf_pkg::CHAR_TAB : tlnf_pkg::CHAR_SPACE;
    end else if (line_numbered) begin
      if (number_format == tlnf_pkg::FORMAT_LEFT) begin
        if (kx < len) begin
          didx = DIW'(len - kx - AW'(1));
          pfx_char = {4'h3, dig[didx]};
        end
      end else if (kx < wx - len) begin
        pfx_char = (number_format == tlnf_pkg::FORMAT_ZEROS) ?
                   tlnf_pkg::CHAR_ZERO : tlnf_pkg::CHAR_SPACE;
      end else begin
        didx = DIW'(wx - kx - AW'(1));
        pfx_char = {4'h3, dig[didx]};
      end
    end
  end

  always_comb begin
    delim_sel = cnt[0] ? delimiter_pair[7:0] : delimiter_pair[15:8];
    case (cmd.emit_sel)
      tlnf_pkg::SEL_PREFIX:  emit_char = pfx_char;
      tlnf_pkg::SEL_HELD:    emit_char = delim_sel;
      tlnf_pkg::SEL_BYTE:    emit_char = in_byte;
      default:               emit_char = tlnf_pkg::CHAR_NEWLINE;
    endcase
  end

  always_comb begin
    st.eoi = in_eoi;
    st.phase = line_phase;
    st.matched = delimiter_matched;
    st.is_nl = (in_byte == tlnf_pkg::CHAR_NEWLINE);
    st.is_d0 = (in_byte == delimiter_pair[15:8]);
    st.match_next = (delimiter_matched < 3'd6) &&
                    (in_byte == (delimiter_matched[0] ? delimiter_pair[7:0]
                                                      : delimiter_pair[15:8]));
    st.numbered_next = numbered_next;
    st.out_free = !numbered_valid || !numbered_stall;
    st.pfx_end = (cnt == w);
    st.held_end = (cnt == CW'(delimiter_matched - 3'd1));
    st.conv_done = (ccnt == KW'(NUMBER_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section_styles  <= 6'd41;
      line_increment  <= 32'd1;
      start_number    <= 32'd1;
      blank_group     <= 16'd1;
      number_width    <= 5'd6;
      number_format   <= 2'd1;
      restart_disable <= 1'b0;
      delimiter_pair  <= 16'd23610;
      line_number     <= NUMBER_BITS'(1);
      blank_run       <= 16'd0;
      current_section <= tlnf_pkg::SEC_BODY;
      delimiter_matched <= 3'd0;
      line_phase      <= tlnf_pkg::PH_START;
      line_numbered   <= 1'b0;
      numbered_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tlnf_pkg::REG_SECTION_STYLES:  section_styles <= cfg_data[5:0];
          tlnf_pkg::REG_LINE_INCREMENT:  line_increment <= cfg_data;
          tlnf_pkg::REG_START_NUMBER: begin
            start_number <= cfg_data;
            line_number <= NUMBER_BITS'(XW'(cfg_data));
          end
          tlnf_pkg::REG_BLANK_GROUP:     blank_group <= cfg_data[15:0];
          tlnf_pkg::REG_NUMBER_WIDTH:    number_width <= cfg_data[4:0];
          tlnf_pkg::REG_NUMBER_FORMAT:   number_format <= cfg_data[1:0];
          tlnf_pkg::REG_RESTART_DISABLE: restart_disable <= cfg_data[0];
          default:                       delimiter_pair <= cfg_data[15:0];
        endcase
      end
      if (cmd.begin_line) begin
        blank_run <= blank_next;
        line_numbered <= numbered_next;
      end
      if (cmd.conv_load) begin
        line_number <= line_number + inc_x[NUMBER_BITS-1:0];
      end
      if (cmd.switch_sec) begin
        blank_run <= 16'd0;
        if (delimiter_matched == tlnf_pkg::MATCH_FOOTER) begin
          current_section <= tlnf_pkg::SEC_FOOTER;
        end else if (delimiter_matched == tlnf_pkg::MATCH_BODY) begin
          current_section <= tlnf_pkg::SEC_BODY;
        end else begin
          current_section <= tlnf_pkg::SEC_HEADER;
          if (!restart_disable) begin
            line_number <= start_x[NUMBER_BITS-1:0];
          end
        end
      end
      if (cmd.set_state) begin
        delimiter_matched <= cmd.match_new;
        line_phase <= cmd.phase_new;
      end
      if (cmd.emit) begin
        numbered_valid <= 1'b1;
      end else if (!numbered_stall) begin
        numbered_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_byte <= input_byte;
      in_eoi <= end_of_input;
    end
    if (cmd.emit) begin
      out_byte <= emit_char;
      run_last <= cmd.last;
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end
    if (cmd.conv_load) begin
      bin <= line_number;
      ccnt <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        dig[i] <= 4'd0;
      end
    end else if (cmd.conv_step) begin
      bin <= bin << 1;
      ccnt <= ccnt + KW'(1);
      for (int i = 0; i < DIGITS; i++) begin
        logic [3:0] a;
        logic [3:0] b;
        a = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
        if (i == 0) begin
          b = {a[2:0], bin[NUMBER_BITS-1]};
        end else begin
          b = (dig[i-1] >= 4'd5) ? dig[i-1] + 4'd3 : dig[i-1];
          b = {a[2:0], b[3]};
        end
        dig[i] <= b;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/text_line_numbering_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_numbering_filter
// Copies a text stream to its output with a line number prefix on each line.
// ----------------------------------------------------------------------------
// One text beat is taken at a time: text_stall stays high from the beat
// until every output byte it causes is registered. A byte inside a line
// passes the accepting, decision, output and closing states. A beat that
// starts a line passes the decision state, then the shift-and-adjust decimal
// converter when the line is numbered, then sends one output beat per cycle
// unless stalled: the prefix of width+1 bytes, any held delimiter bytes, the
// byte itself or a newline, and ends with the closing state before the next
// beat is taken. The last output beat of each text beat with output carries
// run_last. When the receiver holds numbered_stall, the output register
// keeps its beat and the sequencer waits. Settings are written through
// cfg_valid with cfg_ready always high; the user must write them only while
// the block is idle, which the block does not enforce. Reset restores the
// default settings, numbering at the start value in the body section.
// ----------------------------------------------------------------------------
module text_line_numbering_filter #(
  parameter int MAX_WIDTH   = 16,
  parameter int NUMBER_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        text_valid,
  output logic             text_stall,
  input  wire logic [7:0]  input_byte,
  input  wire logic        end_of_input,
  output logic             numbered_valid,
  input  wire logic        numbered_stall,
  output logic [7:0]       out_byte,
  output logic             run_last
);

  tlnf_pkg::cmd_t    cmd;
  tlnf_pkg::status_t st;

  assign cfg_ready = 1'b1;

  tlnf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .st         (st),
    .cmd        (cmd)
  );

  tlnf_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .input_byte     (input_byte),
    .end_of_input   (end_of_input),
    .numbered_valid (numbered_valid),
    .numbered_stall (numbered_stall),
    .out_byte       (out_byte),
    .run_last       (run_last),
    .cmd            (cmd),
    .st             (st)
  );

endmodule
`default_nettype wire
